// ===== rtl/sacv_pkg.sv =====
// ----------------------------------------------------------------------------
// sacv_pkg
// Shared types and constants of the sample autocovariance core.
// ----------------------------------------------------------------------------
package sacv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LAG_W    = 5;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROP = 2'd2;

    // result kind codes
    localparam logic KIND_VAR  = 1'b0;
    localparam logic KIND_ACOV = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE_RD,
        S_BASE_LD,
        S_LAG,
        S_ACC,
        S_DRAIN,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_D,
        S_COMB,
        S_DIV,
        S_EMIT
    } t_state;

    // multiplier operand select
    typedef enum logic [1:0] {
        MSEL_X,
        MSEL_Y,
        MSEL_D
    } t_msel;

    // controller to datapath commands
    typedef struct packed {
        logic             wr;
        logic             base_rd;
        logic             base_ld;
        logic             acc_clr;
        logic             rd;
        logic             mul_ld;
        t_msel            msel;
        logic             mul_step;
        logic             st_x;
        logic             st_y;
        logic             comb;
        logic             div_step;
        logic             emit;
        logic             kind;
        logic             last;
        logic [LAG_W-1:0] lag;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic too_few;
        logic rd_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/sacv_smp_if.sv =====
// ----------------------------------------------------------------------------
// sacv_smp_if
// Sample request channel: one signed sample and its last mark.
// ----------------------------------------------------------------------------
interface sacv_smp_if;
    logic                                valid;
    logic                                ready;
    logic signed [sacv_pkg::SAMPLE_W-1:0] sample;
    logic                                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== rtl/sacv_res_if.sv =====
// ----------------------------------------------------------------------------
// sacv_res_if
// Result request channel: variance and autocovariance results.
// ----------------------------------------------------------------------------
interface sacv_res_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [sacv_pkg::LAG_W-1:0]           lag;
    logic signed [sacv_pkg::VALUE_W-1:0]  value;
    logic [sacv_pkg::STATUS_W-1:0]        status;
    logic                                 last_result;

    modport source (output valid, output kind, output lag, output value,
                    output status, output last_result, input ready);
    modport sink   (input valid, input kind, input lag, input value,
                    input status, input last_result, output ready);
endinterface

// ===== rtl/sacv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sacv_cfg_if
// Configuration write channel carrying the max_lag register.
// ----------------------------------------------------------------------------
interface sacv_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sacv_pkg::LAG_W-1:0] max_lag;

    modport source (output valid, output max_lag, input ready);
    modport sink   (input valid, input max_lag, output ready);
endinterface

// ===== rtl/sacv_dp.sv =====
// ----------------------------------------------------------------------------
// sacv_dp
// Datapath: sample memory, per-lag sums, shift-add multiplier,
// restoring divider and the result output register.
// ----------------------------------------------------------------------------
module sacv_dp #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sacv_pkg::t_cmd                        i_cmd,
    input  logic signed [sacv_pkg::SAMPLE_W-1:0]  i_sample,
    output sacv_pkg::t_sts                        o_sts,
    input  logic                                  i_res_ready,
    output logic                                  o_res_valid,
    output logic                                  o_res_kind,
    output logic [sacv_pkg::LAG_W-1:0]            o_res_lag,
    output logic signed [sacv_pkg::VALUE_W-1:0]   o_res_value,
    output logic [sacv_pkg::STATUS_W-1:0]         o_res_status,
    output logic                                  o_res_last
);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);  // sample count
    localparam int IW  = $clog2(MAX_SAMPLES);      // memory index
    localparam int JW  = IW + 6;
    localparam int DVW = sacv_pkg::SAMPLE_W + 1;   // deviation
    localparam int AW  = CW + 17;                  // sum of deviations
    localparam int PRW = 2 * DVW;                  // one product
    localparam int PW  = CW + 33;                  // sum of products
    localparam int MLW = CW + 16;                  // multiplier operand
    localparam int XW  = 2 * CW + 33;              // product magnitude
    localparam int DW  = 2 * CW;                   // denominator
    localparam int NW  = XW + 16;                  // dividend
    localparam int EW  = NW + 64;

    // sample memory
    logic signed [sacv_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic signed [sacv_pkg::SAMPLE_W-1:0] r_rd0, r_rd1, r_base;

    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [IW-1:0] r_i;
    logic [JW-1:0] j_sum;
    logic [CW-1:0] m;
    logic          too_few;

    logic                   r_v1, r_v2, r_v3;
    logic signed [DVW-1:0]  r_u, r_v;
    logic signed [PRW-1:0]  r_prod;
    logic signed [AW-1:0]   r_a, r_b;
    logic signed [PW-1:0]   r_p;
    logic [PW-1:0]          mag_p;
    logic [AW-1:0]          mag_a, mag_b;

    logic [XW-1:0]  r_mc, r_macc, r_x, r_y;
    logic [MLW-1:0] r_ml;
    logic           r_xneg, r_yneg;

    logic [XW-1:0]  num;
    logic           num_neg;
    logic [DW-1:0]  r_den, r_rem;
    logic [NW-1:0]  r_dvd, r_q;
    logic           r_neg;
    logic [DW:0]    rem2;
    logic [EW-1:0]  q_ext, lim, q_sat;
    logic [63:0]    q64;
    logic [63:0]    res_val;

    assign j_sum = JW'(r_i) + JW'(i_cmd.lag);
    assign m     = r_cnt - CW'(i_cmd.lag);

    // status to the controller
    assign too_few = (CW + 6)'(r_cnt) <= (CW + 6)'(i_cmd.lag) + (CW + 6)'(1);
    assign o_sts   = '{too_few:  too_few,
                       rd_last:  CW'(r_i) == m - CW'(1),
                       out_free: !o_res_valid || i_res_ready};

    // memory write and reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_cnt < CW'(MAX_SAMPLES)) begin
            mem[r_cnt[IW-1:0]] <= i_sample;
        end
        if (i_cmd.base_rd || i_cmd.rd) begin
            r_rd0 <= mem[i_cmd.base_rd ? IW'(0) : r_i];
            r_rd1 <= mem[j_sum[IW-1:0]];
        end
        if (i_cmd.base_ld) begin
            r_base <= r_rd0;
        end
    end

    // sample count and dropped flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.emit && i_cmd.last) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.wr) begin
            if (r_cnt < CW'(MAX_SAMPLES)) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // accumulate pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // deviations, sums and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_i <= '0;
            r_a <= '0;
            r_b <= '0;
            r_p <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_i <= r_i + IW'(1);
            end
            if (r_v2) begin
                r_a    <= r_a + AW'(r_u);
                r_b    <= r_b + AW'(r_v);
                r_prod <= r_u * r_v;
            end
            if (r_v3) begin
                r_p <= r_p + PW'(r_prod);
            end
        end
        if (r_v1) begin
            r_u <= DVW'(r_rd0) - DVW'(r_base);
            r_v <= DVW'(r_rd1) - DVW'(r_base);
        end
    end

    assign mag_p = r_p[PW-1] ? ~r_p + PW'(1) : r_p;
    assign mag_a = r_a[AW-1] ? ~r_a + AW'(1) : r_a;
    assign mag_b = r_b[AW-1] ? ~r_b + AW'(1) : r_b;

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_ld) begin
            r_macc <= '0;
            case (i_cmd.msel)
                sacv_pkg::MSEL_X: begin
                    r_mc <= XW'(mag_p);
                    r_ml <= MLW'(m);
                end
                sacv_pkg::MSEL_Y: begin
                    r_mc <= XW'(mag_a);
                    r_ml <= MLW'(mag_b);
                end
                default: begin
                    r_mc <= XW'(m);
                    r_ml <= MLW'(m - CW'(1));
                end
            endcase
        end else if (i_cmd.mul_step) begin
            if (r_ml[0]) begin
                r_macc <= r_macc + r_mc;
            end
            r_mc <= r_mc << 1;
            r_ml <= r_ml >> 1;
        end
        if (i_cmd.st_x) begin
            r_x    <= r_macc;
            r_xneg <= r_p[PW-1];
        end
        if (i_cmd.st_y) begin
            r_y    <= r_macc;
            r_yneg <= (r_a[AW-1] == r_b[AW-1]) && (r_macc != '0);
        end
    end

    // combine m*P and -A*B into a magnitude and a sign
    always_comb begin
        if (r_xneg == r_yneg) begin
            num     = r_x + r_y;
            num_neg = r_xneg;
        end else if (r_x < r_y) begin
            num     = r_y - r_x;
            num_neg = r_yneg;
        end else begin
            num     = r_x - r_y;
            num_neg = r_xneg;
        end
    end

    assign rem2 = {r_rem, r_dvd[NW-1]};

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.comb) begin
            r_den <= r_macc[DW-1:0];
            r_dvd <= {num, 16'b0};
            r_neg <= num_neg;
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= DW'(rem2 - {1'b0, r_den});
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem2[DW-1:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    // clamp to signed 64 bits and apply the sign
    assign q_ext   = EW'(r_q);
    assign lim     = EW'({1'b1, 63'b0}) - EW'(!r_neg);
    assign q_sat   = (q_ext > lim) ? lim : q_ext;
    assign q64     = q_sat[63:0];
    assign res_val = r_neg ? ~q64 + 64'd1 : q64;

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            o_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_res_kind <= i_cmd.kind;
            o_res_lag  <= i_cmd.lag;
            o_res_last <= i_cmd.last;
            if (too_few) begin
                o_res_value  <= '0;
                o_res_status <= sacv_pkg::STAT_FEW;
            end else begin
                o_res_value  <= res_val;
                o_res_status <= r_ovf ? sacv_pkg::STAT_DROP : sacv_pkg::STAT_OK;
            end
        end
    end

endmodule

// ===== rtl/sacv_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacv_ctrl
// Controller: sequences loading, per-lag accumulation, multiply, divide
// and result emission; holds the max_lag register.
// ----------------------------------------------------------------------------
module sacv_ctrl #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LAG     = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_smp_valid,
    input  logic                           i_smp_last,
    output logic                           o_smp_ready,
    input  logic                           i_cfg_valid,
    input  logic [sacv_pkg::LAG_W-1:0]     i_cfg_max_lag,
    output logic                           o_cfg_ready,
    input  sacv_pkg::t_sts                 i_sts,
    output sacv_pkg::t_cmd                 o_cmd
);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int MLW = CW + 16;
    localparam int NW  = 2 * CW + 49;
    localparam int SW  = $clog2(NW + 1);

    sacv_pkg::t_state              r_state, n_state;
    logic [sacv_pkg::LAG_W:0]      r_idx, n_idx;
    logic [SW-1:0]                 r_step, n_step;
    logic [sacv_pkg::LAG_W-1:0]    r_max_lag;
    logic [sacv_pkg::LAG_W-1:0]    top;
    logic                          is_last;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag <= '0;
        end else if (i_cfg_valid) begin
            r_max_lag <= i_cfg_max_lag;
        end
    end

    assign top = ((sacv_pkg::LAG_W + 1)'(r_max_lag) < (sacv_pkg::LAG_W + 1)'(MAX_LAG))
               ? r_max_lag : sacv_pkg::LAG_W'(MAX_LAG);
    assign is_last = r_idx == (sacv_pkg::LAG_W + 1)'(top) + 1'b1;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacv_pkg::S_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step + SW'(1);
        case (r_state)
            sacv_pkg::S_IDLE: begin
                if (i_smp_valid && i_smp_last) begin
                    n_state = sacv_pkg::S_BASE_RD;
                end
            end
            sacv_pkg::S_BASE_RD: n_state = sacv_pkg::S_BASE_LD;
            sacv_pkg::S_BASE_LD: begin
                n_state = sacv_pkg::S_LAG;
                n_idx   = '0;
            end
            sacv_pkg::S_LAG: begin
                n_state = i_sts.too_few ? sacv_pkg::S_EMIT : sacv_pkg::S_ACC;
            end
            sacv_pkg::S_ACC: begin
                n_step = '0;
                if (i_sts.rd_last) begin
                    n_state = sacv_pkg::S_DRAIN;
                end
            end
            sacv_pkg::S_DRAIN: begin
                if (r_step == SW'(2)) begin
                    n_state = sacv_pkg::S_MUL_X;
                    n_step  = '0;
                end
            end
            sacv_pkg::S_MUL_X: begin
                if (r_step == SW'(MLW)) begin
                    n_state = sacv_pkg::S_MUL_Y;
                    n_step  = '0;
                end
            end
            sacv_pkg::S_MUL_Y: begin
                if (r_step == SW'(MLW)) begin
                    n_state = sacv_pkg::S_MUL_D;
                    n_step  = '0;
                end
            end
            sacv_pkg::S_MUL_D: begin
                if (r_step == SW'(MLW)) begin
                    n_state = sacv_pkg::S_COMB;
                end
            end
            sacv_pkg::S_COMB: begin
                n_state = sacv_pkg::S_DIV;
                n_step  = '0;
            end
            sacv_pkg::S_DIV: begin
                if (r_step == SW'(NW - 1)) begin
                    n_state = sacv_pkg::S_EMIT;
                end
            end
            sacv_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    if (is_last) begin
                        n_state = sacv_pkg::S_IDLE;
                    end else begin
                        n_state = sacv_pkg::S_LAG;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = sacv_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.msel  = sacv_pkg::MSEL_X;
        o_cmd.lag   = (r_idx == '0) ? '0 : sacv_pkg::LAG_W'(r_idx - 1'b1);
        o_cmd.kind  = (r_idx == '0) ? sacv_pkg::KIND_VAR : sacv_pkg::KIND_ACOV;
        o_cmd.last  = is_last;
        o_smp_ready = 1'b0;
        case (r_state)
            sacv_pkg::S_IDLE: begin
                o_smp_ready = 1'b1;
                o_cmd.wr    = i_smp_valid;
            end
            sacv_pkg::S_BASE_RD: o_cmd.base_rd = 1'b1;
            sacv_pkg::S_BASE_LD: o_cmd.base_ld = 1'b1;
            sacv_pkg::S_LAG:     o_cmd.acc_clr = !i_sts.too_few;
            sacv_pkg::S_ACC:     o_cmd.rd      = 1'b1;
            sacv_pkg::S_MUL_X: begin
                o_cmd.mul_ld   = r_step == '0;
                o_cmd.mul_step = r_step != '0;
            end
            sacv_pkg::S_MUL_Y: begin
                o_cmd.msel     = sacv_pkg::MSEL_Y;
                o_cmd.st_x     = r_step == '0;
                o_cmd.mul_ld   = r_step == '0;
                o_cmd.mul_step = r_step != '0;
            end
            sacv_pkg::S_MUL_D: begin
                o_cmd.msel     = sacv_pkg::MSEL_D;
                o_cmd.st_y     = r_step == '0;
                o_cmd.mul_ld   = r_step == '0;
                o_cmd.mul_step = r_step != '0;
            end
            sacv_pkg::S_COMB: o_cmd.comb     = 1'b1;
            sacv_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            sacv_pkg::S_EMIT: o_cmd.emit     = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/sample_autocovariance_core.sv =====
// ----------------------------------------------------------------------------
// sample_autocovariance_core
// Unbiased sample variance and autocovariance over a stored sample set.
// ----------------------------------------------------------------------------
// Usage:
//  i_smp takes one signed 16-bit sample per cycle while the core is idle;
//  a sample marked last_sample closes the set and starts the run. Samples
//  beyond MAX_SAMPLES are dropped and the run's results carry the dropped
//  status. i_cfg writes max_lag (always ready; write only while idle).
//  o_res then delivers the variance and one autocovariance for each lag
//  0..min(max_lag, MAX_LAG); the final one has last_result set.
//  The shift-add multiplier works on MLW = CW+16 bits and the divider on
//  NW = 2*CW+49 bits, with CW = clog2(MAX_SAMPLES+1). The per-lag sum
//  loop reads two memory ports per cycle; the multiplier and divider
//  take one bit per cycle. Results with too few samples skip the sums,
//  multiply and divide. A stalled o_res holds its result and the
//  sequencer waits before the next one. Reset clears the count, the
//  dropped flag, max_lag and all control; the sample memory is not
//  cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sample_autocovariance_core #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LAG     = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sacv_smp_if.sink     i_smp,
    sacv_cfg_if.sink     i_cfg,
    sacv_res_if.source   o_res
);
    sacv_pkg::t_cmd cmd;
    sacv_pkg::t_sts sts;

    // sequencer
    sacv_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_LAG     (MAX_LAG)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_smp_valid   (i_smp.valid),
        .i_smp_last    (i_smp.last_sample),
        .o_smp_ready   (i_smp.ready),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_max_lag (i_cfg.max_lag),
        .o_cfg_ready   (i_cfg.ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // arithmetic and storage
    sacv_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample     (i_smp.sample),
        .o_sts        (sts),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_res_kind   (o_res.kind),
        .o_res_lag    (o_res.lag),
        .o_res_value  (o_res.value),
        .o_res_status (o_res.status),
        .o_res_last   (o_res.last_result)
    );

endmodule

// ===== rtl/sacv_chk.sv =====
// ----------------------------------------------------------------------------
// sacv_chk
// Port-level checks of the sample autocovariance core.
// ----------------------------------------------------------------------------
module sacv_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic                              i_res_kind,
    input logic [sacv_pkg::LAG_W-1:0]        i_res_lag,
    input logic [sacv_pkg::VALUE_W-1:0]      i_res_value,
    input logic [sacv_pkg::STATUS_W-1:0]     i_res_status
);
    // a stalled result keeps its value and lag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_value) && $stable(i_res_lag))
        else $error("result changed while stalled");

    // variance always reports lag zero
    a_var_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind == sacv_pkg::KIND_VAR |-> i_res_lag == '0)
        else $error("variance with nonzero lag");

    // too-few results carry a zero value
    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status == sacv_pkg::STAT_FEW |-> i_res_value == '0)
        else $error("too-few result with nonzero value");

    // status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_status == sacv_pkg::STAT_OK
            || i_res_status == sacv_pkg::STAT_FEW || i_res_status == sacv_pkg::STAT_DROP)
        else $error("undefined status code");

endmodule

bind sample_autocovariance_core sacv_chk u_sacv_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_lag    (o_res.lag),
    .i_res_value  (o_res.value),
    .i_res_status (o_res.status)
);
